// ----- rtl/st3d_pkg.sv -----
// Shared types, constants and register codes for the 3-D seven-point stencil.
package st3d_pkg;

  // Default grid limits for the top-level parameters
  localparam int DEF_MAX_X = 256;
  localparam int DEF_MAX_Y = 256;
  localparam int DEF_MAX_Z = 1024;

  localparam int RADIUS      = 1;
  localparam int WEIGHT_FRAC = 14;

  localparam int SAMPLE_W = 32;
  localparam int WEIGHT_W = 16;
  localparam int NTAPS    = 7;
  localparam int NBANK    = 8;
  localparam int PRODW    = SAMPLE_W + WEIGHT_W;
  localparam int ACCW     = PRODW + 3;

  // Tap order along the MAC chain; tap k meets weight ck
  localparam int TAP_C  = 0;
  localparam int TAP_ZM = 1;
  localparam int TAP_ZP = 2;
  localparam int TAP_XM = 3;
  localparam int TAP_XP = 4;
  localparam int TAP_YP = 5;
  localparam int TAP_YM = 6;

  localparam logic signed [ACCW-1:0] ROUND_HALF = ACCW'(64'sd1 <<< (WEIGHT_FRAC - 1));
  localparam logic signed [ACCW-1:0] SAT_MAX    = ACCW'(64'sd2147483647);
  localparam logic signed [ACCW-1:0] SAT_MIN    = ACCW'(-64'sd2147483648);

  // Configuration port
  localparam int CFG_AW    = 6;
  localparam int REG_IDX_W = 3;
  localparam int CFG_DW    = 64;

  localparam logic [REG_IDX_W-1:0] REG_GRID_X       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GRID_Y       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GRID_Z       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SWEEP_MARGIN = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WEIGHTS_LOW  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_WEIGHTS_HIGH = 3'd5;

  typedef struct packed {
    logic [8:0]  grid_x;
    logic [8:0]  grid_y;
    logic [10:0] grid_z;
    logic [9:0]  sweep_margin;
    logic [63:0] weights_low;
    logic [47:0] weights_high;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               grid_start;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [7:0]         pos_x;
    logic [7:0]         pos_y;
    logic [9:0]         pos_z;
    logic               written;
    logic               last;
  } out_item_t;

  // Center data that rides along the MAC chain
  typedef struct packed {
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [9:0] pos_z;
    logic       written;
    logic       last;
  } cell_meta_t;

  typedef logic [NTAPS-1:0][SAMPLE_W-1:0] taps_t;

endpackage

// ----- rtl/st3d_cfg.sv -----
// APB-style configuration register file for the stencil.
module st3d_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [st3d_pkg::CFG_AW-1:0]   paddr,
  input  logic [st3d_pkg::CFG_DW-1:0]   pwdata,
  output logic [st3d_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output st3d_pkg::cfg_t                cfg
);
  import st3d_pkg::*;

  cfg_t                 cfg_r;
  logic [REG_IDX_W-1:0] idx;
  logic                 wen;

  assign pready = 1'b1;
  assign idx    = paddr[CFG_AW-1:3];
  assign wen    = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_x       <= 9'd256;
      cfg_r.grid_y       <= 9'd256;
      cfg_r.grid_z       <= 11'd256;
      cfg_r.sweep_margin <= 10'd1;
      cfg_r.weights_low  <= '0;
      cfg_r.weights_high <= '0;
    end else if (wen) begin
      case (idx)
        REG_GRID_X:       cfg_r.grid_x       <= pwdata[8:0];
        REG_GRID_Y:       cfg_r.grid_y       <= pwdata[8:0];
        REG_GRID_Z:       cfg_r.grid_z       <= pwdata[10:0];
        REG_SWEEP_MARGIN: cfg_r.sweep_margin <= pwdata[9:0];
        REG_WEIGHTS_LOW:  cfg_r.weights_low  <= pwdata;
        REG_WEIGHTS_HIGH: cfg_r.weights_high <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GRID_X:       prdata = CFG_DW'(cfg_r.grid_x);
      REG_GRID_Y:       prdata = CFG_DW'(cfg_r.grid_y);
      REG_GRID_Z:       prdata = CFG_DW'(cfg_r.grid_z);
      REG_SWEEP_MARGIN: prdata = CFG_DW'(cfg_r.sweep_margin);
      REG_WEIGHTS_LOW:  prdata = cfg_r.weights_low;
      REG_WEIGHTS_HIGH: prdata = CFG_DW'(cfg_r.weights_high);
      default:          prdata = '0;
    endcase
  end

endmodule

// ----- rtl/st3d_bank.sv -----
// One plane-store bank: one write port, two registered read ports.
module st3d_bank #(
  parameter int AW = 14
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic                            wen,
  input  logic [AW-1:0]                   waddr,
  input  logic [st3d_pkg::SAMPLE_W-1:0]   wdata,
  input  logic [AW-1:0]                   raddr_a,
  input  logic [AW-1:0]                   raddr_b,
  output logic [st3d_pkg::SAMPLE_W-1:0]   rdata_a,
  output logic [st3d_pkg::SAMPLE_W-1:0]   rdata_b
);
  import st3d_pkg::*;

  logic [SAMPLE_W-1:0] mem [2**AW];
  logic [SAMPLE_W-1:0] rdata_a_r;
  logic [SAMPLE_W-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  // Read-before-write on a shared address; hold while the pipeline stalls
  always_ff @(posedge clk) begin
    if (en) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ----- rtl/st3d_cell.sv -----
// MAC cell: multiplies its tap by its weight and adds to the running sum.
module st3d_cell (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic signed [st3d_pkg::WEIGHT_W-1:0]   weight,
  input  logic                                   valid_in,
  input  st3d_pkg::cell_meta_t                   meta_in,
  input  st3d_pkg::taps_t                        taps_in,
  input  logic signed [st3d_pkg::ACCW-1:0]       psum_in,
  output logic                                   valid_out,
  output st3d_pkg::cell_meta_t                   meta_out,
  output st3d_pkg::taps_t                        taps_out,
  output logic signed [st3d_pkg::ACCW-1:0]       psum_out
);
  import st3d_pkg::*;

  logic                     valid_r;
  cell_meta_t               meta_r;
  taps_t                    taps_r;
  taps_t                    taps_nxt;
  logic signed [PRODW-1:0]  prod_r;
  logic signed [PRODW-1:0]  prod_nxt;
  logic signed [ACCW-1:0]   psum_r;

  assign prod_nxt = weight * $signed(taps_in[0]);

  // Shift the remaining taps down so the next cell finds its own at slot 0
  always_comb begin
    for (int i = 0; i < NTAPS - 1; i++) begin
      taps_nxt[i] = taps_in[i+1];
    end
    taps_nxt[NTAPS-1] = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta_r <= meta_in;
      taps_r <= taps_nxt;
      prod_r <= prod_nxt;
      psum_r <= psum_in;
    end
  end

  assign valid_out = valid_r;
  assign meta_out  = meta_r;
  assign taps_out  = taps_r;
  assign psum_out  = psum_r + ACCW'(prod_r);

endmodule

// ----- rtl/stencil_3d_7point.sv -----
// Throughput: one sample per cycle; the plane store has two read ports per bank and
// a seven-cell MAC chain, so the whole pipeline advances together, held only while
// the output register is full and out_stall is high.
// Reset (rst_n low, synchronous) clears position counters and pipeline valids and returns the
// configuration registers to their defaults; the plane store is not cleared.
module stencil_3d_7point #(
  parameter int MAX_X = st3d_pkg::DEF_MAX_X,
  parameter int MAX_Y = st3d_pkg::DEF_MAX_Y,
  parameter int MAX_Z = st3d_pkg::DEF_MAX_Z
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  st3d_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output st3d_pkg::out_item_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [st3d_pkg::CFG_AW-1:0]   paddr,
  input  logic [st3d_pkg::CFG_DW-1:0]   pwdata,
  output logic [st3d_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);
  import st3d_pkg::*;

  localparam int XW   = $clog2(MAX_X);
  localparam int YW   = $clog2(MAX_Y);
  localparam int ZW   = $clog2(MAX_Z);
  localparam int DM1  = (MAX_X > MAX_Y) ? MAX_X : MAX_Y;
  localparam int DM2  = (DM1 > MAX_Z) ? DM1 : MAX_Z;
  localparam int DMAX = (DM2 > 1024) ? DM2 : 1024;
  localparam int CMPW = $clog2(DMAX) + 2;
  localparam int AW   = (XW - 1) + (YW - 1);

  cfg_t cfg;

  st3d_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Effective grid size and margin
  logic [CMPW-1:0] gx, gy, gz, marg;

  assign gx = (cfg.grid_x == '0) ? CMPW'(1) :
              ((CMPW'(cfg.grid_x) > CMPW'(MAX_X)) ? CMPW'(MAX_X) : CMPW'(cfg.grid_x));
  assign gy = (cfg.grid_y == '0) ? CMPW'(1) :
              ((CMPW'(cfg.grid_y) > CMPW'(MAX_Y)) ? CMPW'(MAX_Y) : CMPW'(cfg.grid_y));
  assign gz = (cfg.grid_z == '0) ? CMPW'(1) :
              ((CMPW'(cfg.grid_z) > CMPW'(MAX_Z)) ? CMPW'(MAX_Z) : CMPW'(cfg.grid_z));
  assign marg = (CMPW'(cfg.sweep_margin) < CMPW'(RADIUS)) ? CMPW'(RADIUS)
                                                          : CMPW'(cfg.sweep_margin);

  // Handshake and global pipeline enable
  logic en, accept;
  logic out_valid_r;
  out_item_t out_data_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;
  assign accept   = in_valid && en;

  // Position counters
  logic [XW-1:0] col_r, col_nxt, col_s, x;
  logic [YW-1:0] row_r, row_nxt, row_s, y;
  logic [ZW-1:0] plane_r, plane_nxt, plane_s, z;
  logic [CMPW-1:0] xe, ye, ze, cz;
  logic wr, lst;

  assign col_s   = in_data.grid_start ? '0 : col_r;
  assign row_s   = in_data.grid_start ? '0 : row_r;
  assign plane_s = in_data.grid_start ? '0 : plane_r;
  assign x = (CMPW'(col_s)   >= gx) ? '0 : col_s;
  assign y = (CMPW'(row_s)   >= gy) ? '0 : row_s;
  assign z = (CMPW'(plane_s) >= gz) ? '0 : plane_s;
  assign xe = CMPW'(x);
  assign ye = CMPW'(y);
  assign ze = CMPW'(z);
  assign cz = ze - CMPW'(1);

  assign wr  = (xe >= marg) && (ye >= marg) && (cz >= marg) &&
               (xe + marg < gx) && (ye + marg < gy) && (cz + marg < gz);
  assign lst = (xe + CMPW'(1) == gx) && (ye + CMPW'(1) == gy) && (ze + CMPW'(1) == gz);

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    plane_nxt = plane_r;
    if (accept) begin
      col_nxt   = XW'(xe + CMPW'(1));
      row_nxt   = y;
      plane_nxt = z;
      if (xe + CMPW'(1) >= gx) begin
        col_nxt = '0;
        row_nxt = YW'(ye + CMPW'(1));
        if (ye + CMPW'(1) >= gy) begin
          row_nxt   = '0;
          plane_nxt = ZW'(ze + CMPW'(1));
          if (ze + CMPW'(1) >= gz) begin
            plane_nxt = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      plane_r <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      plane_r <= plane_nxt;
    end
  end

  // Plane store: banks by z slot, row parity and column parity
  logic [XW-1:0] x_m1, x_p1;
  logic [YW-1:0] y_m1, y_p1;
  logic [AW-1:0] addr_c, addr_xm, addr_xp, addr_ym, addr_yp;
  logic z0, y0, x0;

  assign x_m1 = x - 1'b1;
  assign x_p1 = x + 1'b1;
  assign y_m1 = y - 1'b1;
  assign y_p1 = y + 1'b1;
  assign addr_c  = {y[YW-1:1],    x[XW-1:1]};
  assign addr_xm = {y[YW-1:1],    x_m1[XW-1:1]};
  assign addr_xp = {y[YW-1:1],    x_p1[XW-1:1]};
  assign addr_ym = {y_m1[YW-1:1], x[XW-1:1]};
  assign addr_yp = {y_p1[YW-1:1], x[XW-1:1]};
  assign z0 = z[0];
  assign y0 = y[0];
  assign x0 = x[0];

  logic [NBANK-1:0][SAMPLE_W-1:0] rda, rdb;

  for (genvar b = 0; b < NBANK; b++) begin : g_bank
    localparam logic BS  = 1'((b >> 2) & 1);
    localparam logic BPY = 1'((b >> 1) & 1);
    localparam logic BPX = 1'(b & 1);
    logic [AW-1:0] ra, rb;
    logic          we;

    always_comb begin
      ra = addr_c;
      rb = addr_c;
      we = 1'b0;
      if (BS == z0) begin
        we = accept && (BPY == y0) && (BPX == x0);
      end else if ((BPY == y0) && (BPX != x0)) begin
        ra = addr_xm;
        rb = addr_xp;
      end else if (BPY != y0) begin
        ra = addr_ym;
        rb = addr_yp;
      end
    end

    st3d_bank #(.AW(AW)) u_bank (
      .clk     (clk),
      .en      (en),
      .wen     (we),
      .waddr   (addr_c),
      .wdata   (in_data.sample),
      .raddr_a (ra),
      .raddr_b (rb),
      .rdata_a (rda[b]),
      .rdata_b (rdb[b])
    );
  end

  // Stage 1: center info alongside the registered reads
  logic               s1_valid_r;
  cell_meta_t         s1_meta_r;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic [2:0]         s1_sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= accept && (ze != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_meta_r.pos_x   <= xe[7:0];
      s1_meta_r.pos_y   <= ye[7:0];
      s1_meta_r.pos_z   <= cz[9:0];
      s1_meta_r.written <= wr;
      s1_meta_r.last    <= lst;
      s1_sample_r       <= in_data.sample;
      s1_sel_r          <= {z0, y0, x0};
    end
  end

  // Pick each tap from its bank
  logic [2:0] ic, ip, ix, iy;
  taps_t taps0;

  assign ic = s1_sel_r;
  assign ip = {~s1_sel_r[2],  s1_sel_r[1],  s1_sel_r[0]};
  assign ix = {~s1_sel_r[2],  s1_sel_r[1], ~s1_sel_r[0]};
  assign iy = {~s1_sel_r[2], ~s1_sel_r[1],  s1_sel_r[0]};

  always_comb begin
    taps0         = '0;
    taps0[TAP_C]  = rda[ip];
    taps0[TAP_ZM] = rda[ic];
    taps0[TAP_ZP] = s1_sample_r;
    taps0[TAP_XM] = rda[ix];
    taps0[TAP_XP] = rdb[ix];
    taps0[TAP_YP] = rdb[iy];
    taps0[TAP_YM] = rda[iy];
  end

  // MAC chain
  logic [NTAPS-1:0][WEIGHT_W-1:0] wv;
  logic                   c_valid [NTAPS+1];
  cell_meta_t             c_meta  [NTAPS+1];
  taps_t                  c_taps  [NTAPS+1];
  logic signed [ACCW-1:0] c_psum  [NTAPS+1];

  assign wv = {cfg.weights_high, cfg.weights_low};

  assign c_valid[0] = s1_valid_r;
  assign c_meta[0]  = s1_meta_r;
  assign c_taps[0]  = taps0;
  assign c_psum[0]  = ROUND_HALF;

  for (genvar k = 0; k < NTAPS; k++) begin : g_cell
    st3d_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .weight    ($signed(wv[k])),
      .valid_in  (c_valid[k]),
      .meta_in   (c_meta[k]),
      .taps_in   (c_taps[k]),
      .psum_in   (c_psum[k]),
      .valid_out (c_valid[k+1]),
      .meta_out  (c_meta[k+1]),
      .taps_out  (c_taps[k+1]),
      .psum_out  (c_psum[k+1])
    );
  end

  // Round (floor after adding half), saturate, drop value off the margin
  logic signed [ACCW-1:0] shifted;
  logic signed [31:0]     sat_val;
  out_item_t              out_nxt;

  assign shifted = c_psum[NTAPS] >>> WEIGHT_FRAC;

  always_comb begin
    if (shifted > SAT_MAX) begin
      sat_val = SAT_MAX[31:0];
    end else if (shifted < SAT_MIN) begin
      sat_val = SAT_MIN[31:0];
    end else begin
      sat_val = shifted[31:0];
    end
    out_nxt.value   = c_meta[NTAPS].written ? sat_val : '0;
    out_nxt.pos_x   = c_meta[NTAPS].pos_x;
    out_nxt.pos_y   = c_meta[NTAPS].pos_y;
    out_nxt.pos_z   = c_meta[NTAPS].pos_z;
    out_nxt.written = c_meta[NTAPS].written;
    out_nxt.last    = c_meta[NTAPS].last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= c_valid[NTAPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en && c_valid[NTAPS]) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
